[hw/rtl/lzpe_pkg.sv]
// shared constants, types and the hash function of the lz78 phrase encoder
package lzpe_pkg;

   localparam int DEF_DICT_SIZE = 4096;
   localparam int BYTE_W        = 8;
   localparam int OUT_CODE_W    = 12;
   localparam int LIMIT_W       = 13;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
   localparam logic [23:0] HASH_MULT = 24'h9E3779;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic clear_step;
      logic take;
      logic hash;
      logic read;
      logic advance;
      logic hit;
      logic emit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_last;
      logic probe_match;
      logic probe_empty;
      logic out_free;
   } status_type;

   // multiplicative mix of the (parent, byte) key, top bits are the slot
   function automatic logic [23:0] hash_mix(input logic [15:0] parent,
                                            input logic [7:0]  b);
      logic [23:0] key;
      key = {parent, b};
      return key * HASH_MULT;
   endfunction

endpackage

[hw/rtl/lzpe_req_if.sv]
// input channel: one text byte per word
interface lzpe_req_if;
   import lzpe_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

[hw/rtl/lzpe_rsp_if.sv]
// result channel: one emitted phrase pair per word
interface lzpe_rsp_if;
   import lzpe_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OUT_CODE_W-1:0] prefix_code;
   logic [BYTE_W-1:0]     out_byte;
   logic [OUT_CODE_W-1:0] assigned_code;
   logic                  dict_full;

   modport source (output valid, output prefix_code, output out_byte,
                   output assigned_code, output dict_full, input ready);
   modport sink   (input valid, input prefix_code, input out_byte,
                   input assigned_code, input dict_full, output ready);
endinterface

[hw/rtl/lzpe_ctrl.sv]
// controller state machine: clearing pass, hash probe sequencing, emit
module lzpe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lzpe_pkg::status_type  status,
   output lzpe_pkg::cmd_type     cmd
);
   import lzpe_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_HASH;
         end
         ST_HASH: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.probe_match) state_in = ST_IDLE;
            else if (status.probe_empty) state_in = ST_EMIT;
            else state_in = ST_READ;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_HASH: cmd.hash = 1'b1;
         ST_READ: cmd.read = 1'b1;
         ST_CHECK: begin
            cmd.hit     = status.probe_match;
            cmd.advance = !status.probe_match && !status.probe_empty;
         end
         ST_EMIT: cmd.emit = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

[hw/rtl/lzpe_datapath.sv]
// datapath: hashed phrase table, phrase and code registers, result register
module lzpe_datapath #(
   parameter int DICT_SIZE = lzpe_pkg::DEF_DICT_SIZE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lzpe_pkg::cmd_type                 cmd,
   output lzpe_pkg::status_type              status,
   input  logic [lzpe_pkg::BYTE_W-1:0]       req_in_byte,
   input  logic                              csr_wr_en,
   input  logic [lzpe_pkg::LIMIT_W-1:0]      csr_wr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [lzpe_pkg::OUT_CODE_W-1:0]   rsp_prefix_code,
   output logic [lzpe_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [lzpe_pkg::OUT_CODE_W-1:0]   rsp_assigned_code,
   output logic                              rsp_dict_full
);
   import lzpe_pkg::*;

   localparam int CW    = $clog2(DICT_SIZE);
   localparam int NW    = $clog2(DICT_SIZE + 1);
   localparam int SLOTS = 2 * DICT_SIZE;
   localparam int HW    = $clog2(SLOTS);
   localparam int SW    = 2 * CW + BYTE_W;
   localparam int CMPW  = (NW > LIMIT_W) ? NW : LIMIT_W;
   localparam logic [HW-1:0] LAST_SLOT = HW'(SLOTS - 1);

   // slot layout: {code, parent, byte}, code 0 marks an empty slot
   logic [SW-1:0] slot_mem [SLOTS];

   logic [CW-1:0]      cur_ff;
   logic [NW-1:0]      next_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic [HW-1:0]      slot_ff;
   logic [HW-1:0]      clr_ff;
   logic [SW-1:0]      rd_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               valid_ff;
   logic [OUT_CODE_W-1:0] prefix_ff;
   logic [BYTE_W-1:0]     obyte_ff;
   logic [OUT_CODE_W-1:0] assigned_ff;
   logic                  full_ff;

   logic [23:0]   mix;
   logic [HW:0]   mix_top;
   logic [HW:0]   mix_red;
   logic          grow;
   logic [CW-1:0] rd_code;
   logic [CW-1:0] rd_parent;
   logic [BYTE_W-1:0] rd_byte;
   logic          mem_we;
   logic [HW-1:0] mem_addr;
   logic [SW-1:0] mem_wdata;

   // hash of the current phrase and byte, folded into the slot range
   always_comb begin
      mix     = hash_mix(16'(cur_ff), byte_ff);
      mix_top = {1'b0, mix[23 -: HW]};
      if (mix_top >= (HW + 1)'(SLOTS)) mix_red = mix_top - (HW + 1)'(SLOTS);
      else mix_red = mix_top;
   end

   // probe result decode
   assign rd_code   = rd_ff[SW-1 -: CW];
   assign rd_parent = rd_ff[BYTE_W +: CW];
   assign rd_byte   = rd_ff[BYTE_W-1:0];

   // a new entry fits below both the register limit and the table size
   assign grow = (CMPW'(next_ff) < CMPW'(limit_ff)) && (next_ff < NW'(DICT_SIZE));

   assign status.clear_last  = (clr_ff == LAST_SLOT);
   assign status.probe_empty = (rd_code == '0);
   assign status.probe_match = (rd_code != '0) && (rd_parent == cur_ff)
                               && (rd_byte == byte_ff);
   assign status.out_free    = !valid_ff || rsp_ready;

   // table write port: clearing pass or new entry
   always_comb begin
      mem_we    = cmd.clear_step || (cmd.emit && grow);
      mem_addr  = cmd.clear_step ? clr_ff : slot_ff;
      mem_wdata = cmd.clear_step ? '0 : {next_ff[CW-1:0], cur_ff, byte_ff};
   end

   // phrase table memory
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[mem_addr] <= mem_wdata;
      if (cmd.read) rd_ff <= slot_mem[slot_ff];
   end

   // clearing counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step && !status.clear_last) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // phrase state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         next_ff <= NW'(1);
      end else if (cmd.hit) begin
         cur_ff <= rd_code;
      end else if (cmd.emit) begin
         cur_ff <= '0;
         if (grow) next_ff <= next_ff + 1'b1;
      end
   end

   // input byte and probe slot
   always_ff @(posedge clock) begin
      if (cmd.take) byte_ff <= req_in_byte;
      if (cmd.hash) begin
         slot_ff <= mix_red[HW-1:0];
      end else if (cmd.advance) begin
         slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         prefix_ff   <= OUT_CODE_W'(cur_ff);
         obyte_ff    <= byte_ff;
         assigned_ff <= grow ? OUT_CODE_W'(next_ff) : '0;
         full_ff     <= !grow;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_prefix_code   = prefix_ff;
   assign rsp_out_byte      = obyte_ff;
   assign rsp_assigned_code = assigned_ff;
   assign rsp_dict_full     = full_ff;

endmodule

[hw/rtl/lz78_phrase_encoder_core.sv]
// lz78 phrase encoder top level: controller, datapath and channel wiring
//
//   channel   dir   word
//   req_chan  in    in_byte: next text byte
//   rsp_chan  out   prefix_code, out_byte, assigned_code, dict_full
//   csr_*     in    code_limit write, 13 bits, no read-back
//
// A byte that extends a known phrase passes through hash, table read and check;
// a byte that ends a phrase adds an emit step, and every extra collision probe
// repeats the table read and check. The hashed phrase table has 2*DICT_SIZE slots.
// After reset a clearing pass over all 2*DICT_SIZE slots runs before the first byte.
// A result waits in its output register; the next byte is taken meanwhile,
// and only a second result stalls until the first one is taken.
module lz78_phrase_encoder_core #(
   parameter int DICT_SIZE = lzpe_pkg::DEF_DICT_SIZE
) (
   input  logic                          clock,
   input  logic                          reset,
   lzpe_req_if.sink                      req_chan,
   lzpe_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [lzpe_pkg::LIMIT_W-1:0]  csr_wr_data
);
   import lzpe_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller
   lzpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   lzpe_datapath #(
      .DICT_SIZE (DICT_SIZE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_in_byte       (req_chan.in_byte),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_prefix_code   (rsp_chan.prefix_code),
      .rsp_out_byte      (rsp_chan.out_byte),
      .rsp_assigned_code (rsp_chan.assigned_code),
      .rsp_dict_full     (rsp_chan.dict_full)
   );

endmodule

[tb/sv/testbench.sv]
// lz78 phrase encoder testbench: directed and random text checked against a phrase dictionary
`timescale 1ns / 1ps

module testbench;
   import lzpe_pkg::*;

   localparam int DRAIN_CYCLES = 4;        // idle margin once the block is back at rest
   localparam int SETTLE_LIMIT = 20000;
   localparam int HOLD_CYCLES  = 300;
   localparam int CODE_W       = OUT_CODE_W;

   // one emitted phrase pair
   typedef struct packed {
      logic [CODE_W-1:0]  prefix_code;
      logic [BYTE_W-1:0]  out_byte;
      logic [CODE_W-1:0]  assigned_code;
      logic               dict_full;
   } phrase_pair_type;

   // phrase dictionary mirror and queue of pairs still to come
   class phrase_book_type;
      logic [CODE_W-1:0]  child_code [logic [CODE_W+BYTE_W-1:0]];
      logic [LIMIT_W-1:0] next_code;
      logic [LIMIT_W-1:0] code_limit;
      logic [CODE_W-1:0]  cur_code;
      phrase_pair_type    wanted[$];
      int                 errors;

      function new();
         next_code  = LIMIT_W'(1);
         cur_code   = '0;
         code_limit = LIMIT_RESET;
         errors     = 0;
      endfunction

      function void set_limit(input logic [LIMIT_W-1:0] v);
         code_limit = v;
      endfunction

      function int pending();
         return wanted.size();
      endfunction

      // walk the dictionary with one accepted byte
      function void note_byte(input logic [BYTE_W-1:0] b);
         logic [CODE_W+BYTE_W-1:0] key;
         logic [LIMIT_W-1:0]       lim;
         phrase_pair_type          p;
         key = {cur_code, b};
         if (child_code.exists(key)) begin
            cur_code = child_code[key];
            return;
         end
         lim = (code_limit > LIMIT_W'(DEF_DICT_SIZE)) ? LIMIT_W'(DEF_DICT_SIZE) : code_limit;
         p.prefix_code = cur_code;
         p.out_byte    = b;
         if (next_code < lim) begin
            child_code[key] = next_code[CODE_W-1:0];
            p.assigned_code = next_code[CODE_W-1:0];
            p.dict_full     = 1'b0;
            next_code       = LIMIT_W'(next_code + 1'b1);
         end else begin
            p.assigned_code = '0;
            p.dict_full     = 1'b1;
         end
         cur_code = '0;
         wanted.insert(wanted.size(), p);
      endfunction

      // compare one taken result with the oldest pending pair
      function void check_pair(input phrase_pair_type got);
         phrase_pair_type w;
         if (wanted.size() == 0) begin
            $error("result with nothing pending: prefix %0d byte %0d code %0d full %0d",
                   got.prefix_code, got.out_byte, got.assigned_code, got.dict_full);
            errors++;
            return;
         end
         w = wanted.pop_front();
         if (got.prefix_code !== w.prefix_code) begin
            $error("prefix_code: expected %0d, actual %0d", w.prefix_code, got.prefix_code);
            errors++;
         end
         if (got.out_byte !== w.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", w.out_byte, got.out_byte);
            errors++;
         end
         if (got.assigned_code !== w.assigned_code) begin
            $error("assigned_code: expected %0d, actual %0d", w.assigned_code, got.assigned_code);
            errors++;
         end
         if (got.dict_full !== w.dict_full) begin
            $error("dict_full: expected %0d, actual %0d", w.dict_full, got.dict_full);
            errors++;
         end
      endfunction

      function void flag_leftover();
         if (wanted.size() != 0) begin
            $error("%0d results never arrived", wanted.size());
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;
   bit                 calm_tail = 1'b0;
   bit                 stall_rsp = 1'b0;
   logic [BYTE_W-1:0]  sent_text[$];
   phrase_book_type    book = new();

   lzpe_req_if req_chan ();
   lzpe_rsp_if rsp_chan ();

   lz78_phrase_encoder_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // result side ready: short random stalls, one long hold on request
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            stall_rsp = 1'b0;
         end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            rsp_chan.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // check every result word taken
   always @(posedge clock) begin
      phrase_pair_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.prefix_code   = rsp_chan.prefix_code;
         got.out_byte      = rsp_chan.out_byte;
         got.assigned_code = rsp_chan.assigned_code;
         got.dict_full     = rsp_chan.dict_full;
         book.check_pair(got);
      end
   end

   // offer one text byte, with an optional idle burst ahead of it
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      book.note_byte(b);
      sent_text.insert(sent_text.size(), b);
   endtask

   // stop offering and wait for all pending pairs and for the block to be back at rest
   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while ((book.pending() != 0 || req_chan.ready !== 1'b1) && waited < SETTLE_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      book.set_limit(v);
   endtask

   // random text: narrow-alphabet runs and replays build long phrases, plus noise
   task automatic send_text(input int count);
      int n, mode, len, base, span, start, i;
      n = 0;
      while (n < count) begin
         mode = $urandom_range(0, 99);
         if (mode < 60) begin
            len  = $urandom_range(8, 40);
            base = $urandom_range(0, 252);
            span = $urandom_range(2, 4);
            for (i = 0; i < len; i++)
               send_byte(BYTE_W'(base + $urandom_range(0, span - 1)));
         end else if (mode < 85 && sent_text.size() > 40) begin
            len   = $urandom_range(5, 30);
            start = $urandom_range(0, sent_text.size() - len - 1);
            for (i = 0; i < len; i++)
               send_byte(sent_text[start + i]);
         end else begin
            len = $urandom_range(1, 10);
            for (i = 0; i < len; i++)
               send_byte(BYTE_W'($urandom_range(0, 255)));
         end
         n += len;
      end
   endtask

   // main sequence
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // limit zero: every byte emits a full pair from the root
      write_limit(13'd0);
      send_byte(8'h00);
      send_byte(8'hFF);

      // limit one behaves the same
      write_limit(13'd1);
      send_byte(8'h5A);

      // limit two: one entry, then full, and that entry stays searchable
      write_limit(13'd2);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h00);

      // above the table size: clamps to the dictionary size
      write_limit(13'd8191);
      repeat (4) begin
         send_byte(8'hAA);
         send_byte(8'h55);
      end

      // limit lowered under the next free code
      write_limit(13'd3);
      send_byte(8'h12);
      send_byte(8'h12);
      send_byte(8'hAA);

      // mid limit: new codes stay below 300, then full pairs
      write_limit(13'd300);
      send_text(400);

      // wide open, with one long result hold that backs up the input
      write_limit(13'd8191);
      send_text(225);
      stall_rsp = 1'b1;
      send_text(225);
      settle();
      send_text(150);

      // reset value again, then no idling at all in the second half
      write_limit(13'd4096);
      send_text(200);
      calm_tail = 1'b1;
      send_text(200);

      settle();
      book.flag_leftover();
      if (book.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
